@@ rtl/core/stopwatch_lap_progress_display_unit_assert.svh @@
// assertion helpers shared by the stopwatch display modules
// both expect clk and rst in the enclosing module
`ifndef STOPWATCH_LAP_PROGRESS_DISPLAY_UNIT_ASSERT_SVH
`define STOPWATCH_LAP_PROGRESS_DISPLAY_UNIT_ASSERT_SVH

// same-cycle implication
`define SLPD_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define SLPD_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/core/slpd_pkg.sv @@
package slpd_pkg;

  localparam logic [19:0] LIMIT_MAX   = 20'd599900;
  localparam logic [19:0] LIMIT_RESET = 20'd599900;
  localparam logic [15:0] HOLD_RESET  = 16'd2000;
  localparam int unsigned MINUTE_MS   = 60000;
  localparam int unsigned RING_CELLS  = 28;
  localparam int unsigned MINUTES_MAX = 9;
  localparam logic [16:0] DIV100_MUL  = 17'd83887;
  localparam int unsigned DIV100_SHIFT = 23;
  localparam logic [13:0] CODE_MAX    = 14'd9599;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } run_mode_t;

  typedef enum logic [0:0] {
    CFG_LIMIT = 1'b0,
    CFG_HOLD  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        start_press;
    logic        lap_press;
    logic        reset_press;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  run_mode;
    logic        lap_shown;
    logic [13:0] time_code;
    logic [7:0]  row_0;
    logic [7:0]  row_1;
    logic [7:0]  row_2;
    logic [7:0]  row_3;
    logic [7:0]  row_4;
    logic [7:0]  row_5;
    logic [7:0]  row_6;
    logic [7:0]  row_7;
  } result_t;

  // shown time and flags after the state update
  typedef struct packed {
    logic        status;
    logic [1:0]  run_mode;
    logic        lap_shown;
    logic [19:0] elapsed;
  } disp_req_t;

  // shown time split into whole minutes and the rest
  typedef struct packed {
    logic        status;
    logic [1:0]  run_mode;
    logic        lap_shown;
    logic [3:0]  minutes;
    logic [15:0] ms;
  } split_t;

  function automatic logic [19:0] minute_base(input logic [3:0] m);
    logic [19:0] b;
    case (m)
      4'd0:    b = 20'd0;
      4'd1:    b = 20'd60000;
      4'd2:    b = 20'd120000;
      4'd3:    b = 20'd180000;
      4'd4:    b = 20'd240000;
      4'd5:    b = 20'd300000;
      4'd6:    b = 20'd360000;
      4'd7:    b = 20'd420000;
      4'd8:    b = 20'd480000;
      4'd9:    b = 20'd540000;
      default: b = 20'd0;
    endcase
    return b;
  endfunction

  // ring walks the top row, right column, bottom row backwards, left column up
  function automatic logic [2:0] ring_row(input logic [4:0] i);
    logic [4:0] t;
    if (i < 5'd8) t = 5'd0;
    else if (i < 5'd15) t = i - 5'd7;
    else if (i < 5'd22) t = 5'd7;
    else t = 5'd28 - i;
    return t[2:0];
  endfunction

  function automatic logic [2:0] ring_col(input logic [4:0] i);
    logic [4:0] t;
    if (i < 5'd8) t = i;
    else if (i < 5'd15) t = 5'd7;
    else if (i < 5'd22) t = 5'd21 - i;
    else t = 5'd0;
    return t[2:0];
  endfunction

  function automatic logic [3:0] glyph_row(input logic lap, input logic [1:0] mode,
                                           input logic [1:0] idx);
    logic [15:0] g;
    if (lap) begin
      g = 16'h888f;
    end else begin
      case (mode)
        MODE_RUNNING: g = 16'h63f2;
        MODE_PAUSED:  g = 16'haaaa;
        default:      g = 16'hf99f;
      endcase
    end
    return g[4'(4'd12 - {idx, 2'b00}) +: 4];
  endfunction

endpackage

@@ rtl/core/stopwatch_lap_progress_display_unit.sv @@
// stopwatch with lap split, driving a time code and an 8x8 progress matrix
// input channel: in_valid/in_ready carry one update beat (time, press events)
// output channel: out_valid/out_ready carry one result beat per update
// config channel: cfg_valid/cfg_ready write register cfg_index (0 limit,
//   1 lap hold) with cfg_data; always ready, write only while idle
// four register stages: input, state update, minute split, result
// an accepted beat passes the state update, minute split and result registers to out_data
// throughput: one beat per cycle while out_ready does not stall; the watch state is updated in
//   the cycle the beat leaves the input register
// a stall on out_ready holds the result and backs up the stages one by one;
//   in_ready stays high while any stage has room
// reset (rst, synchronous): pipeline empty, watch stopped at zero, no lap,
//   limit 599900 ms, lap hold 2000 ms
`include "stopwatch_lap_progress_display_unit_assert.svh"

module stopwatch_lap_progress_display_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slpd_pkg::item_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slpd_pkg::result_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  slpd_pkg::cfg_reg_t  cfg_index,
  input  logic [19:0]         cfg_data
);
  import slpd_pkg::*;

  logic [19:0] cfg_limit;
  logic [15:0] cfg_hold;

  item_t     item_a;
  disp_req_t req, req_b;
  split_t    split, split_c;
  result_t   res;
  logic      va, vb, vc;
  logic      en_a, en_b, en_c, en_o, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_limit <= LIMIT_RESET;
      cfg_hold  <= HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT: cfg_limit <= cfg_data;
        CFG_HOLD:  cfg_hold  <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // each stage moves when the next one is empty or moving
  assign en_o     = !out_valid || out_ready;
  assign en_c     = !vc || en_o;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;
  assign step     = va && en_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_o) out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) item_a <= in_data;
    if (step) req_b <= req;
    if (en_c && vb) split_c <= split;
    if (en_o && vc) out_data <= res;
  end

  slpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_limit (cfg_limit),
    .cfg_hold  (cfg_hold),
    .item      (item_a),
    .step      (step),
    .req       (req)
  );

  slpd_split u_split (
    .req   (req_b),
    .split (split)
  );

  slpd_render u_render (
    .split (split_c),
    .res   (res)
  );

  `SLPD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `SLPD_ASSERT_NOW(a_code_range, out_valid, out_data.time_code <= CODE_MAX, "time code out of range")
  `SLPD_ASSERT_NOW(a_mode_code, out_valid, out_data.run_mode != 2'd3, "unused run mode shown")

endmodule

@@ rtl/core/slpd_ctrl.sv @@
`include "stopwatch_lap_progress_display_unit_assert.svh"

module slpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic [19:0]         cfg_limit,
  input  logic [15:0]         cfg_hold,
  input  slpd_pkg::item_t     item,
  input  logic                step,
  output slpd_pkg::disp_req_t req
);
  import slpd_pkg::*;

  run_mode_t   run_state, run_state_next;
  logic [19:0] banked_ms, banked_ms_next;
  logic [31:0] run_start_ms, run_start_ms_next;
  logic [19:0] lap_value_ms, lap_value_ms_next;
  logic [31:0] lap_start_ms, lap_start_ms_next;
  logic        lap_visible, lap_visible_next;
  logic [31:0] last_update_ms, last_update_ms_next;
  logic        have_last_update, have_last_update_next;

  logic [19:0] lim;
  logic [31:0] since_last, at, inc, lap_age;
  logic [20:0] sum;
  logic [19:0] cur;
  logic        bw, running, inval_press, bad_lap;

  always_comb begin
    if (cfg_limit == 20'd0) lim = 20'd1;
    else if (cfg_limit > LIMIT_MAX) lim = LIMIT_MAX;
    else lim = cfg_limit;

    since_last = item.now_ms - last_update_ms;
    bw = have_last_update && since_last[31];
    // a backwards beat is judged at the last good time
    at = bw ? last_update_ms : item.now_ms;
    running = (run_state == MODE_RUNNING);
    inc = at - run_start_ms;
    sum = {1'b0, banked_ms} + (running ? {1'b0, inc[19:0]} : 21'd0);
    if (running && (inc > {12'd0, lim})) cur = lim;
    else if (sum > {1'b0, lim}) cur = lim;
    else cur = sum[19:0];

    run_state_next        = run_state;
    banked_ms_next        = banked_ms;
    run_start_ms_next     = run_start_ms;
    lap_value_ms_next     = lap_value_ms;
    lap_start_ms_next     = lap_start_ms;
    lap_visible_next      = lap_visible;
    last_update_ms_next   = last_update_ms;
    have_last_update_next = have_last_update;
    inval_press           = 1'b0;
    bad_lap               = 1'b0;
    lap_age               = 32'd0;

    if (!bw) begin
      if (item.reset_press) begin
        run_state_next    = MODE_STOPPED;
        banked_ms_next    = 20'd0;
        run_start_ms_next = item.now_ms;
        lap_value_ms_next = 20'd0;
        lap_start_ms_next = item.now_ms;
        lap_visible_next  = 1'b0;
      end else if (item.start_press && item.lap_press) begin
        inval_press = 1'b1;
      end else begin
        if (item.start_press) begin
          if (running) begin
            banked_ms_next = cur;
            run_state_next = MODE_PAUSED;
          end else begin
            run_start_ms_next = item.now_ms;
            run_state_next    = MODE_RUNNING;
          end
        end
        if (item.lap_press) begin
          lap_value_ms_next = cur;
          lap_start_ms_next = item.now_ms;
          lap_visible_next  = 1'b1;
        end
        if (cur >= lim) begin
          banked_ms_next = lim;
          run_state_next = MODE_STOPPED;
        end
      end
      lap_age = item.now_ms - lap_start_ms_next;
      bad_lap = lap_visible_next && lap_age[31];
      if (lap_visible_next && !lap_age[31] && (lap_age > {16'd0, cfg_hold})) begin
        lap_visible_next = 1'b0;
      end
      if (!bad_lap) begin
        last_update_ms_next   = item.now_ms;
        have_last_update_next = 1'b1;
      end
    end

    // live time after any update at now equals cur, or zero after a reset press
    req.status    = bw || inval_press || bad_lap;
    req.run_mode  = run_state_next;
    req.lap_shown = lap_visible_next;
    if (lap_visible_next) req.elapsed = lap_value_ms_next;
    else if (item.reset_press && !bw) req.elapsed = 20'd0;
    else req.elapsed = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state        <= MODE_STOPPED;
      banked_ms        <= 20'd0;
      run_start_ms     <= 32'd0;
      lap_value_ms     <= 20'd0;
      lap_start_ms     <= 32'd0;
      lap_visible      <= 1'b0;
      last_update_ms   <= 32'd0;
      have_last_update <= 1'b0;
    end else if (step) begin
      run_state        <= run_state_next;
      banked_ms        <= banked_ms_next;
      run_start_ms     <= run_start_ms_next;
      lap_value_ms     <= lap_value_ms_next;
      lap_start_ms     <= lap_start_ms_next;
      lap_visible      <= lap_visible_next;
      last_update_ms   <= last_update_ms_next;
      have_last_update <= have_last_update_next;
    end
  end

  `SLPD_ASSERT_NOW(a_banked_cap, 1'b1, banked_ms <= LIMIT_MAX, "banked time above limit")
  `SLPD_ASSERT_NOW(a_lap_cap, lap_visible, lap_value_ms <= LIMIT_MAX, "lap value above limit")
  `SLPD_ASSERT_NEXT(a_reset_press, step && item.reset_press && !bw,
                    run_state == MODE_STOPPED && !lap_visible && banked_ms == 20'd0,
                    "reset press did not clear the watch")

endmodule

@@ rtl/core/slpd_split.sv @@
module slpd_split (
  input  slpd_pkg::disp_req_t req,
  output slpd_pkg::split_t    split
);
  import slpd_pkg::*;

  logic [3:0]  minutes;
  logic [19:0] rest;

  always_comb begin
    minutes = 4'd0;
    // independent threshold compares, counted
    for (int k = 1; k <= MINUTES_MAX; k++) begin
      minutes = minutes + {3'd0, (req.elapsed >= 20'(k * MINUTE_MS))};
    end
    rest = req.elapsed - minute_base(minutes);
    split.status    = req.status;
    split.run_mode  = req.run_mode;
    split.lap_shown = req.lap_shown;
    split.minutes   = minutes;
    split.ms        = rest[15:0];
  end

endmodule

@@ rtl/core/slpd_render.sv @@
module slpd_render (
  input  slpd_pkg::split_t  split,
  output slpd_pkg::result_t res
);
  import slpd_pkg::*;

  logic [32:0] prod;
  logic [9:0]  deci;
  logic [20:0] ms28;
  logic [7:0]  rows [8];
  logic [2:0]  r, c;
  logic [3:0]  g;

  always_comb begin
    // floor(ms / 100) by reciprocal, exact for ms below one minute
    prod = {17'd0, split.ms} * {16'd0, DIV100_MUL};
    deci = prod[DIV100_SHIFT +: 10];
    ms28 = {5'd0, split.ms} * 21'd28;

    for (int i = 0; i < 8; i++) rows[i] = 8'd0;

    // cell i lit when ms * 28 reaches i minutes-fractions, cell 0 when ms is nonzero
    for (int i = 0; i < RING_CELLS; i++) begin
      r = ring_row(5'(i));
      c = ring_col(5'(i));
      if ((split.ms != 16'd0) && (ms28 >= 21'(i * MINUTE_MS))) begin
        rows[r][3'd7 - c] = 1'b1;
      end
    end

    for (int j = 0; j < 4; j++) begin
      g = glyph_row(split.lap_shown, split.run_mode, 2'(j));
      rows[j + 2] = rows[j + 2] | {2'b00, g, 2'b00};
    end

    res.status    = split.status;
    res.run_mode  = split.run_mode;
    res.lap_shown = split.lap_shown;
    res.time_code = 14'({10'd0, split.minutes} * 14'd1000) + {4'd0, deci};
    res.row_0     = rows[0];
    res.row_1     = rows[1];
    res.row_2     = rows[2];
    res.row_3     = rows[3];
    res.row_4     = rows[4];
    res.row_5     = rows[5];
    res.row_6     = rows[6];
    res.row_7     = rows[7];
  end

endmodule
